### design/tdm_pkg.sv
package tdm_pkg;

    // tile geometry and store size
    localparam int TILE_W     = 8;
    localparam int TILE_H     = 8;
    localparam int MAX_UNIQUE = 256;

    localparam int TILE_PIX    = TILE_W * TILE_H;
    localparam int STORE_DEPTH = MAX_UNIQUE * TILE_PIX;

    // payload widths fixed by the interface
    localparam int PIXEL_W = 32;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 16;

    // derived index widths
    localparam int POS_W  = (TILE_PIX > 1) ? $clog2(TILE_PIX) : 1;
    localparam int SLOT_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [PIXEL_W-1:0] t_pixel;

    typedef struct packed {
        logic [ID_W-1:0]    unique_id;
        logic               is_new;
        logic [COUNT_W-1:0] use_count;
        logic               overflow;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_CNT,
        S_RESULT
    } t_state;

endpackage

### design/tdm_in_if.sv
interface tdm_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdm_pkg::PIXEL_W-1:0]   pixel;
    logic                          last_tile;

    modport source (output valid, output pixel, output last_tile, input ready);
    modport sink   (input valid, input pixel, input last_tile, output ready);
endinterface

### design/tdm_out_if.sv
interface tdm_out_if;
    logic                          valid;
    logic                          ready;
    logic [tdm_pkg::ID_W-1:0]      unique_id;
    logic                          is_new;
    logic [tdm_pkg::COUNT_W-1:0]   use_count;
    logic                          overflow;

    modport source (output valid, output unique_id, output is_new, output use_count,
                    output overflow, input ready);
    modport sink   (input valid, input unique_id, input is_new, input use_count,
                    input overflow, output ready);
endinterface

### design/tile_dedup_matcher.sv
// per pixel: accepted in idle, then one store read per distinct tile held;
// a tile's final pixel then adds the use-count increment (on a match) and result.
// results go to an output register, so the next pixel is taken while one waits.
// synchronous active-low reset empties the table; the memories are not cleared.
module tile_dedup_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdm_in_if.sink     i_in,
    tdm_out_if.source  o_out
);

    tdm_pkg::t_state  r_state, n_state;
    tdm_pkg::t_pos    r_pos, n_pos;
    tdm_pkg::t_cnt    r_total, n_total;
    tdm_pkg::t_cnt    r_slot, n_slot;
    tdm_pkg::t_pixel  r_pixel, n_pixel;
    logic             r_last, n_last;
    logic             r_found, n_found;
    tdm_pkg::t_slot   r_hit, n_hit;
    logic             r_cmp_vld, n_cmp_vld;
    tdm_pkg::t_slot   r_cmp_slot, n_cmp_slot;
    tdm_pkg::t_slot   r_res_slot, n_res_slot;
    tdm_pkg::t_result r_res, n_res;
    logic             r_out_valid, n_out_valid;
    tdm_pkg::t_result r_out, n_out;

    // memory ports
    logic                           store_we;
    tdm_pkg::t_addr                 store_waddr;
    tdm_pkg::t_addr                 store_raddr;
    tdm_pkg::t_pixel                store_q;
    logic                           alive_we;
    logic                           alive_wdata;
    logic                           alive_q;
    logic                           cnt_we;
    logic [tdm_pkg::COUNT_W-1:0]    cnt_q;

    logic accept;
    logic room;
    logic pos_last;
    logic pix_eq;
    logic hit;

    assign accept   = i_in.valid && i_in.ready;
    assign room     = (r_total < tdm_pkg::t_cnt'(tdm_pkg::MAX_UNIQUE));
    assign pos_last = (r_pos == tdm_pkg::t_pos'(tdm_pkg::TILE_PIX - 1));

    // pixel compare against the same position of one stored tile
    assign pix_eq = (store_q == r_pixel);
    assign hit    = ((r_pos == '0) || alive_q) && pix_eq;

    // address of a pixel: slot * TILE_PIX + position
    assign store_waddr = tdm_pkg::t_addr'(r_total[tdm_pkg::SLOT_W-1:0])
                       * tdm_pkg::t_addr'(tdm_pkg::TILE_PIX)
                       + tdm_pkg::t_addr'(r_pos);
    assign store_raddr = tdm_pkg::t_addr'(r_slot[tdm_pkg::SLOT_W-1:0])
                       * tdm_pkg::t_addr'(tdm_pkg::TILE_PIX)
                       + tdm_pkg::t_addr'(r_pos);
    assign store_we    = accept && room;

    assign alive_we    = r_cmp_vld;
    assign alive_wdata = hit;

    tdm_ram #(
        .DEPTH (tdm_pkg::STORE_DEPTH),
        .WIDTH (tdm_pkg::PIXEL_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_in.pixel),
        .i_raddr (store_raddr),
        .o_rdata (store_q)
    );

    // per-slot flag: still equal at every position so far
    tdm_ram #(
        .DEPTH (tdm_pkg::MAX_UNIQUE),
        .WIDTH (1)
    ) u_alive (
        .i_clk   (i_clk),
        .i_we    (alive_we),
        .i_waddr (r_cmp_slot),
        .i_wdata (alive_wdata),
        .i_raddr (r_slot[tdm_pkg::SLOT_W-1:0]),
        .o_rdata (alive_q)
    );

    tdm_ram #(
        .DEPTH (tdm_pkg::MAX_UNIQUE),
        .WIDTH (tdm_pkg::COUNT_W)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_res_slot),
        .i_wdata (r_res.use_count),
        .i_raddr (r_hit),
        .o_rdata (cnt_q)
    );

    assign i_in.ready      = (r_state == tdm_pkg::S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.unique_id = r_out.unique_id;
    assign o_out.is_new    = r_out.is_new;
    assign o_out.use_count = r_out.use_count;
    assign o_out.overflow  = r_out.overflow;

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_total     = r_total;
        n_slot      = r_slot;
        n_pixel     = r_pixel;
        n_last      = r_last;
        n_found     = r_found;
        n_hit       = r_hit;
        n_cmp_vld   = 1'b0;
        n_cmp_slot  = r_cmp_slot;
        n_res_slot  = r_res_slot;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        cnt_we      = 1'b0;

        // first surviving slot at the final position is the match
        if (r_cmp_vld && pos_last && hit && !r_found) begin
            n_found = 1'b1;
            n_hit   = r_cmp_slot;
        end

        case (r_state)
            tdm_pkg::S_IDLE: begin
                if (accept) begin
                    n_pixel = i_in.pixel;
                    n_last  = i_in.last_tile;
                    n_slot  = '0;
                    if (r_pos == '0) begin
                        n_found = 1'b0;
                    end
                    n_state = tdm_pkg::S_SWEEP;
                end
            end
            tdm_pkg::S_SWEEP: begin
                if (r_slot < r_total) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_slot = r_slot[tdm_pkg::SLOT_W-1:0];
                    n_slot     = r_slot + 1'b1;
                end else begin
                    n_state = tdm_pkg::S_DRAIN;
                end
            end
            tdm_pkg::S_DRAIN: begin
                if (!pos_last) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = tdm_pkg::S_IDLE;
                end else begin
                    n_pos = '0;
                    if (r_found) begin
                        n_res_slot          = r_hit;
                        n_res.unique_id     = tdm_pkg::ID_W'(r_hit);
                        n_res.is_new        = 1'b0;
                        n_res.overflow      = 1'b0;
                        n_state             = tdm_pkg::S_CNT;
                    end else if (room) begin
                        n_res_slot          = r_total[tdm_pkg::SLOT_W-1:0];
                        n_res.unique_id     = tdm_pkg::ID_W'(r_total);
                        n_res.is_new        = 1'b1;
                        n_res.use_count     = tdm_pkg::COUNT_W'(1);
                        n_res.overflow      = 1'b0;
                        n_state             = tdm_pkg::S_RESULT;
                    end else begin
                        n_res_slot          = '0;
                        n_res.unique_id     = '0;
                        n_res.is_new        = 1'b0;
                        n_res.use_count     = '0;
                        n_res.overflow      = 1'b1;
                        n_state             = tdm_pkg::S_RESULT;
                    end
                end
            end
            tdm_pkg::S_CNT: begin
                // saturating increment of the matched count
                if (cnt_q == tdm_pkg::COUNT_MAX) begin
                    n_res.use_count = cnt_q;
                end else begin
                    n_res.use_count = cnt_q + 1'b1;
                end
                n_state = tdm_pkg::S_RESULT;
            end
            tdm_pkg::S_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    cnt_we      = !r_res.overflow;
                    if (r_last) begin
                        n_total = '0;
                    end else if (r_res.is_new) begin
                        n_total = r_total + 1'b1;
                    end
                    n_state = tdm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tdm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdm_pkg::S_IDLE;
            r_pos       <= '0;
            r_total     <= '0;
            r_slot      <= '0;
            r_found     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_total     <= n_total;
            r_slot      <= n_slot;
            r_found     <= n_found;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pixel    <= n_pixel;
        r_last     <= n_last;
        r_hit      <= n_hit;
        r_cmp_slot <= n_cmp_slot;
        r_res_slot <= n_res_slot;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule

### design/tdm_ram.sv
module tdm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
